@@ hw/rtl/stateful_flow_firewall_core_macros.svh @@
// Assertion macros shared by the flow firewall RTL.
// Uses clk and rst of the including module; empty when SYNTHESIS is defined.
`ifndef STATEFUL_FLOW_FIREWALL_CORE_MACROS_SVH
`define STATEFUL_FLOW_FIREWALL_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define SFF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define SFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFF_ASSERT_NOW(label, ante, cons, msg)
`define SFF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ hw/rtl/sff_pkg.sv @@
// Types and constants of the stateful flow firewall.
// No dependencies; imported by every module of the block.
`default_nettype none

package sff_pkg;

  // Flow table geometry
  localparam int FLOW_ENTRIES = 16;
  localparam int IDX_W        = $clog2(FLOW_ENTRIES);

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_TIMEOUT  = 1'b1;
  localparam logic [15:0] DEFAULT_TIMEOUT = 16'd5;

  // Input request kinds
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_PACKET = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        from_external;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
  } req_t;

  typedef struct packed {
    logic pass;
    logic flow_hit;
    logic table_full;
  } res_t;

  // Work classes decided by the front end
  typedef enum logic [1:0] {
    OP_TICK,
    OP_BYPASS,
    OP_FILTER
  } op_t;

  typedef struct packed {
    op_t  op;
    req_t pkt;
  } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/sff_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on sff_pkg and the assertion macro header.
`default_nettype none
`include "stateful_flow_firewall_core_macros.svh"

module sff_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sff_pkg::req_t item,
  input  logic          filter_enable,
  output sff_pkg::cmd_t head,
  output logic          head_valid,
  input  logic          pop
);
  import sff_pkg::*;

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  cmd_t              cmd_in;

  assign busy       = (count == QCNT_W'(QUEUE_DEPTH));
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign head       = queue[rd_ptr];

  // Classify the incoming request
  always_comb begin
    cmd_in.pkt = item;
    if (item.kind == KIND_TICK) begin
      cmd_in.op = OP_TICK;
    end else if (filter_enable) begin
      cmd_in.op = OP_FILTER;
    end else begin
      cmd_in.op = OP_BYPASS;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  `SFF_ASSERT_NOW(a_pop_nonempty, pop, count != '0, "pop from empty request queue")
  `SFF_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "fill level missed a push")
  `SFF_ASSERT_NEXT(a_count_down, pop && !push, count == $past(count) - 1'b1, "fill level missed a pop")

endmodule

`default_nettype wire

@@ hw/rtl/sff_back.sv @@
// Back end: flow table, parallel match with expiry, write-back and result register.
// Depends on sff_pkg and the assertion macro header.
`default_nettype none
`include "stateful_flow_firewall_core_macros.svh"

module sff_back (
  input  logic          clk,
  input  logic          rst,
  input  sff_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  input  logic [15:0]   flow_timeout,
  output logic          done,
  output sff_pkg::res_t result
);
  import sff_pkg::*;

  typedef enum logic {
    S_EVAL,
    S_COMMIT
  } state_t;

  state_t state;

  // Flow table
  logic [FLOW_ENTRIES-1:0] valid;
  logic [31:0] ent_src_addr  [FLOW_ENTRIES];
  logic [31:0] ent_dst_addr  [FLOW_ENTRIES];
  logic [15:0] ent_src_port  [FLOW_ENTRIES];
  logic [15:0] ent_dst_port  [FLOW_ENTRIES];
  logic [7:0]  ent_proto     [FLOW_ENTRIES];
  logic [31:0] ent_last_seen [FLOW_ENTRIES];
  logic [31:0] now_seconds;

  // Combinational evaluation of the head request
  logic [FLOW_ENTRIES-1:0] alive;
  logic [FLOW_ENTRIES-1:0] match;
  logic                    hit_any;
  logic                    free_any;
  logic [IDX_W-1:0]        hit_idx;
  logic [IDX_W-1:0]        free_idx;

  // Evaluation held for the commit cycle
  logic [FLOW_ENTRIES-1:0] alive_q;
  logic                    hit_q;
  logic                    free_q;
  logic [IDX_W-1:0]        hit_idx_q;
  logic [IDX_W-1:0]        free_idx_q;
  req_t                    pkt_q;
  logic                    insert;
  logic                    pop_filter;

  assign pop        = (state == S_EVAL) && head_valid;
  assign pop_filter = pop && (head.op == OP_FILTER);
  assign insert     = !hit_q && !pkt_q.from_external && free_q;

  // Expire, match and pick the lowest hit and free entry
  always_comb begin
    logic [31:0] age;
    logic        fwd;
    logic        rev;
    age = '0;
    fwd = 1'b0;
    rev = 1'b0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      age      = now_seconds - ent_last_seen[i];
      alive[i] = valid[i] && (age <= {16'd0, flow_timeout});
      fwd = (ent_src_addr[i] == head.pkt.src_addr) &&
            (ent_src_port[i] == head.pkt.src_port) &&
            (ent_dst_addr[i] == head.pkt.dst_addr) &&
            (ent_dst_port[i] == head.pkt.dst_port);
      rev = (ent_src_addr[i] == head.pkt.dst_addr) &&
            (ent_src_port[i] == head.pkt.dst_port) &&
            (ent_dst_addr[i] == head.pkt.src_addr) &&
            (ent_dst_port[i] == head.pkt.src_port);
      match[i] = alive[i] && (ent_proto[i] == head.pkt.protocol) && (fwd || rev);
    end
    hit_any  = |match;
    free_any = |(~alive);
    hit_idx  = '0;
    free_idx = '0;
    for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!alive[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // Sequence requests, hold valid bits, clock and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_EVAL;
      valid       <= '0;
      now_seconds <= '0;
      done        <= 1'b0;
      result      <= '0;
    end else begin
      // Strobe on commit, or at once for requests that skip the table
      done <= (state == S_COMMIT) || (pop && (head.op != OP_FILTER));
      unique case (state)
        S_EVAL: begin
          if (head_valid) begin
            unique case (head.op)
              OP_TICK: begin
                now_seconds <= now_seconds + 1'b1;
                result      <= '{pass: 1'b1, flow_hit: 1'b0, table_full: 1'b0};
              end
              OP_BYPASS: begin
                result <= '{pass: 1'b1, flow_hit: 1'b0, table_full: 1'b0};
              end
              OP_FILTER: begin
                state <= S_COMMIT;
              end
              default: begin
                result <= '{pass: 1'b1, flow_hit: 1'b0, table_full: 1'b0};
              end
            endcase
          end
        end
        S_COMMIT: begin
          // Drop expired entries, then claim the free entry on insert
          valid <= alive_q | (insert ? (FLOW_ENTRIES'(1) << free_idx_q) : '0);
          state <= S_EVAL;
          if (hit_q) begin
            result <= '{pass: 1'b1, flow_hit: 1'b1, table_full: 1'b0};
          end else if (pkt_q.from_external) begin
            result <= '{pass: 1'b0, flow_hit: 1'b0, table_full: 1'b0};
          end else if (free_q) begin
            result <= '{pass: 1'b1, flow_hit: 1'b0, table_full: 1'b0};
          end else begin
            result <= '{pass: 1'b1, flow_hit: 1'b0, table_full: 1'b1};
          end
        end
        default: begin
          state <= S_EVAL;
        end
      endcase
    end
  end

  // Capture the evaluation and write back refresh or insert
  always_ff @(posedge clk) begin
    if (pop_filter) begin
      alive_q    <= alive;
      hit_q      <= hit_any;
      free_q     <= free_any;
      hit_idx_q  <= hit_idx;
      free_idx_q <= free_idx;
      pkt_q      <= head.pkt;
    end
    if (state == S_COMMIT) begin
      if (hit_q) begin
        ent_last_seen[hit_idx_q] <= now_seconds;
      end else if (insert) begin
        ent_src_addr[free_idx_q]  <= pkt_q.src_addr;
        ent_dst_addr[free_idx_q]  <= pkt_q.dst_addr;
        ent_src_port[free_idx_q]  <= pkt_q.src_port;
        ent_dst_port[free_idx_q]  <= pkt_q.dst_port;
        ent_proto[free_idx_q]     <= pkt_q.protocol;
        ent_last_seen[free_idx_q] <= now_seconds;
      end
    end
  end

  `SFF_ASSERT_NEXT(a_commit_done, state == S_COMMIT, done, "commit gave no result")
  `SFF_ASSERT_NEXT(a_filter_commit, pop_filter, state == S_COMMIT, "filter skipped commit")
  `SFF_ASSERT_NOW(a_full_pass, done && result.table_full, result.pass && !result.flow_hit, "bad full")
  `SFF_ASSERT_NOW(a_hit_pass, done && result.flow_hit, result.pass, "matched flow was dropped")

endmodule

`default_nettype wire

@@ hw/rtl/stateful_flow_firewall_core.sv @@
// A filtered packet passes the request queue, the match in S_EVAL and the table
// write-back in S_COMMIT before its result is strobed; a tick or unfiltered packet gets
// its result as it leaves the queue. The back end takes no new request while it commits
// a filtered packet; otherwise one per cycle. A 2-entry request queue parts the sides.
// Reset: synchronous; clears valid bits, seconds counter, queue and registers
// (filtering off, timeout 5). Results cannot be stalled by the receiver.
`default_nettype none

module stateful_flow_firewall_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  sff_pkg::req_t                    item,
  output logic                             done,
  output sff_pkg::res_t                    result,
  input  logic                             cfg_write,
  input  logic [sff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sff_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sff_pkg::*;

  logic        filter_enable;
  logic [15:0] flow_timeout;
  cmd_t        head;
  logic        head_valid;
  logic        pop;

  // Decode configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      flow_timeout  <= DEFAULT_TIMEOUT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        CFG_FLOW_TIMEOUT:  flow_timeout  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  sff_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .filter_enable (filter_enable),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop)
  );

  sff_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .flow_timeout (flow_timeout),
    .done         (done),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_stateful_flow_firewall_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stateful_flow_firewall_core: directed flows, then random traffic.
// Depends on sff_pkg and the core RTL; keeps its own flow table to predict every verdict.
module tb_stateful_flow_firewall_core;
  import sff_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_COUNT    = 7;
  localparam int PHASE_REQUESTS = 104;
  localparam int POOL_MAX       = 24;
  localparam logic [31:0] HOST_A = 32'h0A00_0001;
  localparam logic [31:0] HOST_B = 32'hC633_6407;
  localparam logic [31:0] HOST_C = 32'hC633_6408;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic                  busy;
  req_t                  item      = '0;
  logic                  done;
  res_t                  result;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  stateful_flow_firewall_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Requests waiting to be driven, verdicts waiting to come back
  req_t        request_q[$];
  res_t        verdict_q[$];
  req_t        flow_pool[$];
  int unsigned idle_pct = 0;
  bit          taken    = 1'b0;

  // Flow table copy used for prediction
  bit          fw_valid     [FLOW_ENTRIES];
  req_t        fw_flow      [FLOW_ENTRIES];
  logic [31:0] fw_last_seen [FLOW_ENTRIES];
  logic [31:0] fw_now       = '0;
  bit          fw_enable    = 1'b0;
  logic [15:0] fw_timeout   = DEFAULT_TIMEOUT;

  int n_errors = 0, n_checked = 0, n_ticks = 0, n_hits = 0, n_inserts = 0;
  int n_drops = 0, n_full = 0, n_expired = 0;

  // Predict the verdict of one request and update the table copy
  function automatic res_t firewall_verdict(req_t r);
    res_t        v;
    int          hit_idx;
    int          free_idx;
    logic [31:0] age;
    bit          fwd, rev;
    v = '{pass: 1'b1, flow_hit: 1'b0, table_full: 1'b0};
    hit_idx = -1;
    free_idx = -1;
    if (r.kind == KIND_TICK) begin
      fw_now = fw_now + 32'd1;
      n_ticks++;
    end else if (fw_enable) begin
      // free stale flows first, even when the packet ends up dropped
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
        age = fw_now - fw_last_seen[i];
        if (fw_valid[i] && age > {16'h0, fw_timeout}) begin
          fw_valid[i] = 1'b0;
          n_expired++;
        end
      end
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
        if (fw_valid[i]) begin
          fwd = fw_flow[i].src_addr == r.src_addr && fw_flow[i].src_port == r.src_port &&
                fw_flow[i].dst_addr == r.dst_addr && fw_flow[i].dst_port == r.dst_port;
          rev = fw_flow[i].src_addr == r.dst_addr && fw_flow[i].src_port == r.dst_port &&
                fw_flow[i].dst_addr == r.src_addr && fw_flow[i].dst_port == r.src_port;
          if (hit_idx < 0 && fw_flow[i].protocol == r.protocol && (fwd || rev))
            hit_idx = i;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (hit_idx >= 0) begin
        v.flow_hit = 1'b1;
        fw_last_seen[hit_idx] = fw_now;
        n_hits++;
      end else if (r.from_external) begin
        v.pass = 1'b0;
        n_drops++;
      end else if (free_idx >= 0) begin
        fw_valid[free_idx] = 1'b1;
        fw_flow[free_idx] = r;
        fw_last_seen[free_idx] = fw_now;
        n_inserts++;
      end else begin
        v.table_full = 1'b1;
        n_full++;
      end
    end
    return v;
  endfunction

  function automatic req_t make_tick();
    req_t r;
    r.kind = KIND_TICK;
    r.from_external = 1'($urandom_range(1));
    r.src_addr = $urandom;
    r.dst_addr = $urandom;
    r.src_port = 16'($urandom);
    r.dst_port = 16'($urandom);
    r.protocol = 8'($urandom);
    return r;
  endfunction

  function automatic req_t make_packet(logic ext, logic [31:0] sa, logic [31:0] da,
                                       logic [15:0] sp, logic [15:0] dp, logic [7:0] pr);
    req_t r;
    r.kind = KIND_PACKET;
    r.from_external = ext;
    r.src_addr = sa;
    r.dst_addr = da;
    r.src_port = sp;
    r.dst_port = dp;
    r.protocol = pr;
    return r;
  endfunction

  // Mostly real conversations: outbound opens, replies, retransmits; the rest noise
  function automatic req_t random_request();
    req_t        r;
    req_t        f;
    int unsigned roll;
    roll = $urandom_range(99);
    r = make_tick();
    if (roll < 15)
      return r;
    r.kind = KIND_PACKET;
    if (roll < 45 || flow_pool.size() == 0) begin
      // open or reuse an outbound flow from a small host set
      r.from_external = 1'b0;
      r.src_addr = 32'h0A00_0000 | $urandom_range(15);
      r.dst_addr = 32'hC0A8_0000 | $urandom_range(3);
      r.src_port = 16'($urandom_range(1031, 1024));
      case ($urandom_range(2))
        0: r.dst_port = 16'd80;
        1: r.dst_port = 16'd443;
        default: r.dst_port = 16'd53;
      endcase
      case ($urandom_range(2))
        0: r.protocol = PROTO_TCP;
        1: r.protocol = PROTO_UDP;
        default: r.protocol = 8'd1;
      endcase
      if (flow_pool.size() < POOL_MAX)
        flow_pool.push_back(r);
      else
        flow_pool[$urandom_range(POOL_MAX - 1)] = r;
    end else if (roll < 88) begin
      // follow up a known flow, usually from outside, in either direction
      f = flow_pool[$urandom_range(flow_pool.size() - 1)];
      r = f;
      r.from_external = ($urandom_range(99) < 70);
      if ($urandom_range(1)) begin
        r.src_addr = f.dst_addr;
        r.dst_addr = f.src_addr;
        r.src_port = f.dst_port;
        r.dst_port = f.src_port;
      end
      // spoil one field now and then
      case ($urandom_range(9))
        0: r.protocol = r.protocol ^ 8'h10;
        1: r.src_port = r.src_port + 16'd1;
        2: r.dst_port = r.dst_port + 16'd1;
        default: ;
      endcase
    end
    return r;
  endfunction

  // Drive requests at the falling edge; advance only once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (start)
        void'(request_q.pop_front());
      if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        item <= request_q[0];
      end else begin
        start <= 1'b0;
      end
    end
    taken = 1'b0;
  end

  // Sample at the rising edge: register writes, accepted requests, results
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst) begin
      if (cfg_write) begin
        if (cfg_index == CFG_FILTER_ENABLE)
          fw_enable = cfg_data[0];
        else if (cfg_index == CFG_FLOW_TIMEOUT)
          fw_timeout = cfg_data;
      end
      if (start && !busy) begin
        taken = 1'b1;
        verdict_q.push_back(firewall_verdict(item));
      end
      if (done) begin
        if (verdict_q.size() == 0) begin
          n_errors++;
          $display("%0t: result with nothing expected: %p", $time, result);
        end else begin
          want = verdict_q.pop_front();
          n_checked++;
          if (result.pass !== want.pass) begin
            n_errors++;
            $display("%0t: pass expected %b actual %b", $time, want.pass, result.pass);
          end
          if (result.flow_hit !== want.flow_hit) begin
            n_errors++;
            $display("%0t: flow_hit expected %b actual %b", $time, want.flow_hit,
                     result.flow_hit);
          end
          if (result.table_full !== want.table_full) begin
            n_errors++;
            $display("%0t: table_full expected %b actual %b", $time, want.table_full,
                     result.table_full);
          end
        end
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (start && !busy) || done)
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, verdict_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Hold until every request is taken and every verdict back, then idle a while
  task automatic settle(int extra);
    while (request_q.size() != 0 || start || verdict_q.size() != 0)
      @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    bit          en;
    logic [15:0] timeout;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // filtering off after reset: everything passes
    request_q.push_back(make_tick());
    request_q.push_back(make_packet(1'b1, HOST_B, HOST_A, 16'd80, 16'd1000, PROTO_TCP));
    settle(SETTLE_CYCLES);
    write_reg(CFG_FILTER_ENABLE, 16'h0001);

    // open a flow, answer it both ways, then near misses on protocol, ports and source address
    request_q.push_back(make_packet(1'b0, HOST_A, HOST_B, 16'd1000, 16'd80, PROTO_TCP));
    request_q.push_back(make_packet(1'b1, HOST_B, HOST_A, 16'd80, 16'd1000, PROTO_TCP));
    request_q.push_back(make_packet(1'b1, HOST_A, HOST_B, 16'd1000, 16'd80, PROTO_TCP));
    request_q.push_back(make_packet(1'b1, HOST_B, HOST_A, 16'd80, 16'd1000, PROTO_UDP));
    request_q.push_back(make_packet(1'b1, HOST_B, HOST_A, 16'd81, 16'd1000, PROTO_TCP));
    request_q.push_back(make_packet(1'b1, HOST_B, HOST_A, 16'd80, 16'd1001, PROTO_TCP));
    request_q.push_back(make_packet(1'b1, HOST_C, HOST_A, 16'd80, 16'd1000, PROTO_TCP));
    // all-ones and all-zero flows
    request_q.push_back(make_packet(1'b0, '1, '1, '1, '1, '1));
    request_q.push_back(make_packet(1'b1, '1, '1, '1, '1, '1));
    request_q.push_back(make_packet(1'b0, '0, '0, '0, '0, '0));
    request_q.push_back(make_packet(1'b1, '0, '0, '0, '0, '0));
    // age equal to the timeout still holds; one second more expires
    repeat (5) request_q.push_back(make_tick());
    request_q.push_back(make_packet(1'b1, HOST_B, HOST_A, 16'd80, 16'd1000, PROTO_TCP));
    repeat (6) request_q.push_back(make_tick());
    request_q.push_back(make_packet(1'b1, HOST_B, HOST_A, 16'd80, 16'd1000, PROTO_TCP));
    settle(SETTLE_CYCLES);

    // random traffic over several register settings and sender gap rates
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin en = 1'b1; timeout = 16'd5;     idle_pct = 0;  end
        1: begin en = 1'b1; timeout = 16'd1;     idle_pct = 83; end
        2: begin en = 1'b1; timeout = 16'hFFFF;  idle_pct = 10; end
        3: begin en = 1'b0; timeout = 16'd100;   idle_pct = 0;  end
        4: begin en = 1'b1; timeout = 16'd0;     idle_pct = 83; end
        5: begin en = 1'b1; timeout = 16'd3;     idle_pct = 10; end
        default: begin en = 1'b1; timeout = 16'd30; idle_pct = 0; end
      endcase
      write_reg(CFG_FLOW_TIMEOUT, timeout);
      write_reg(CFG_FILTER_ENABLE, {15'($urandom_range(32767)), en});
      // two halves, with the sender drained in between
      for (int half = 0; half < 2; half++) begin
        repeat (PHASE_REQUESTS / 2) request_q.push_back(random_request());
        settle(half == 0 ? 0 : SETTLE_CYCLES);
      end
    end

    settle(SETTLE_CYCLES);
    $display("summary: %0d verdicts checked, %0d ticks, %0d flow hits, %0d inserts",
             n_checked, n_ticks, n_hits, n_inserts);
    $display("summary: %0d external drops, %0d table-full, %0d expiries, %0d mismatches",
             n_drops, n_full, n_expired, n_errors);
    if (n_errors == 0 && verdict_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ stateful_flow_firewall_core.f @@
+incdir+hw/rtl
hw/rtl/sff_pkg.sv
hw/rtl/sff_front.sv
hw/rtl/sff_back.sv
hw/rtl/stateful_flow_firewall_core.sv
tb/sv/tb_stateful_flow_firewall_core.sv
